FILE: rtl/core/rsa_crt_decrypt_defines.svh
// ----------------------------------------------------------------------------
// rsa_crt_decrypt_defines
// assertion macros for the rsa crt decryption block
// ----------------------------------------------------------------------------
`ifndef RSA_CRT_DECRYPT_DEFINES_SVH
`define RSA_CRT_DECRYPT_DEFINES_SVH
`ifndef SYNTH
`define RCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rcd assertion failed");
`define RCD_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("rcd sequencing check failed");
`else
`define RCD_ASSERT(lbl, prop)
`define RCD_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

FILE: rtl/core/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// shared widths, register map and divider interface types
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int PRIME_W  = 32;
    localparam int EXP_W    = 64;
    localparam int DIVD_W   = 64;
    localparam int CNT_W    = $clog2(DIVD_W);
    localparam int SGN_W    = PRIME_W + 2;
    localparam int PROD_W   = 2 * SGN_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;

    localparam logic [1:0] REG_EXPONENT = 2'd0;
    localparam logic [1:0] REG_PRIME_P  = 2'd1;
    localparam logic [1:0] REG_PRIME_Q  = 2'd2;

    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [PRIME_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIVD_W-1:0]   quotient;
        logic [PRIME_W-1:0]  remainder;
    } t_div_rsp;

endpackage

FILE: rtl/core/rcd_div.sv
// ----------------------------------------------------------------------------
// rcd_div
// restoring divider, one quotient bit per cycle, 64-bit by 32-bit
// ----------------------------------------------------------------------------
module rcd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcd_pkg::t_div_req i_req,
    output rcd_pkg::t_div_rsp o_rsp
);
    import rcd_pkg::*;

    logic [PRIME_W-1:0] r_rem;
    logic [DIVD_W-1:0]  r_quo;
    logic [PRIME_W-1:0] r_dvs;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [PRIME_W:0]   w_sh;
    logic               w_ge;
    logic [PRIME_W:0]   w_sub;

    assign w_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_dvs};
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[PRIME_W-1:0] : w_sh[PRIME_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: rtl/core/rsa_crt_decrypt.sv
// every modular reduction runs on the shared divider; one item takes three setup
// reductions, the euclid steps, per half a base reduction plus a reduced square per
// exponent bit and a reduced multiply per set bit, and two reductions to recombine
// throughput: one item at a time, next request taken after the result is read
// reset: synchronous active-low, registers return to d=1, p=5, q=3
// ----------------------------------------------------------------------------
// rsa_crt_decrypt
// crt rsa decryption sequenced around one divider and one multiplier
// ----------------------------------------------------------------------------
`include "rsa_crt_decrypt_defines.svh"
module rsa_crt_decrypt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,   // [31:0] ciphertext
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,   // [63:0] plaintext
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rcd_pkg::ADDR_W-1:0] paddr,
    input  logic [rcd_pkg::DATA_W-1:0] pwdata,
    output logic [rcd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rcd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DP, S_DQ, S_INV0, S_INVCHK, S_INVDIV, S_INVMUL, S_INVUPD,
        S_INVFIN, S_PWB, S_PWCHK, S_PWMA, S_PWGA, S_PWRA, S_PWMB, S_PWGB,
        S_PWRB, S_DIFF, S_DSUB, S_HMUL, S_HGO, S_HRED, S_MMUL, S_MADD, S_OUT
    } t_state;

    t_state                    r_state;
    logic [EXP_W-1:0]          r_d;
    logic [PRIME_W-1:0]        r_p, r_q, r_c;
    logic [PRIME_W-1:0]        r_dp, r_dq, r_qinv;
    logic [PRIME_W-1:0]        r_r0, r_r1, r_r2, r_qt;
    logic signed [SGN_W-1:0]   r_t0, r_t1;
    logic [PRIME_W-1:0]        r_mod, r_exp, r_acc, r_b;
    logic                      r_pw_q;
    logic [PRIME_W-1:0]        r_m1, r_m2, r_diff, r_h;
    logic [PRIME_W:0]          r_sum;
    logic signed [PROD_W-1:0]  r_prod;
    logic [63:0]               r_out;
    t_div_req                  r_div_req;
    t_div_rsp                  w_div_rsp;

    logic signed [SGN_W-1:0]   w_ma, w_mb;
    logic                      w_wr;
    logic signed [SGN_W-1:0]   w_tfix;

    rcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= EXP_W'(1);
            r_p <= PRIME_W'(5);
            r_q <= PRIME_W'(3);
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_EXPONENT: r_d <= pwdata;
                REG_PRIME_P:  r_p <= pwdata[PRIME_W-1:0];
                REG_PRIME_Q:  r_q <= pwdata[PRIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_EXPONENT: prdata = r_d;
            REG_PRIME_P:  prdata = {32'd0, r_p};
            REG_PRIME_Q:  prdata = {32'd0, r_q};
            default:      prdata = '0;
        endcase
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_INVMUL: begin w_ma = {2'b0, r_qt};   w_mb = r_t1;            end
            S_PWMA:   begin w_ma = {2'b0, r_acc};  w_mb = {2'b0, r_b};     end
            S_PWMB:   begin w_ma = {2'b0, r_b};    w_mb = {2'b0, r_b};     end
            S_HMUL:   begin w_ma = {2'b0, r_qinv}; w_mb = {2'b0, r_diff};  end
            S_MMUL:   begin w_ma = {2'b0, r_h};    w_mb = {2'b0, r_q};     end
            default:  begin w_ma = '0;             w_mb = '0;              end
        endcase
    end

    assign w_tfix = r_t0[SGN_W-1] ? r_t0 + $signed({2'b0, r_p}) : r_t0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            r_prod          <= w_ma * w_mb;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_c <= s_axis_tdata;
                        if (r_p < PRIME_W'(2) || r_q < PRIME_W'(2)) begin
                            r_out   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_div_req <= '{1'b1, r_d, r_p - 1'b1};
                            r_state   <= S_DP;
                        end
                    end
                end
                S_DP: if (w_div_rsp.done) begin
                    r_dp      <= w_div_rsp.remainder;
                    r_div_req <= '{1'b1, r_d, r_q - 1'b1};
                    r_state   <= S_DQ;
                end
                S_DQ: if (w_div_rsp.done) begin
                    r_dq      <= w_div_rsp.remainder;
                    r_div_req <= '{1'b1, {32'd0, r_q}, r_p};
                    r_state   <= S_INV0;
                end
                S_INV0: if (w_div_rsp.done) begin
                    r_r0    <= r_p;
                    r_r1    <= w_div_rsp.remainder;
                    r_t0    <= '0;
                    r_t1    <= SGN_W'(1);
                    r_state <= S_INVCHK;
                end
                S_INVCHK: begin
                    if (r_r1 == '0) begin
                        r_state <= S_INVFIN;
                    end else begin
                        r_div_req <= '{1'b1, {32'd0, r_r0}, r_r1};
                        r_state   <= S_INVDIV;
                    end
                end
                S_INVDIV: if (w_div_rsp.done) begin
                    r_qt    <= w_div_rsp.quotient[PRIME_W-1:0];
                    r_r2    <= w_div_rsp.remainder;
                    r_state <= S_INVMUL;
                end
                S_INVMUL: r_state <= S_INVUPD;
                S_INVUPD: begin
                    r_t0    <= r_t1;
                    r_t1    <= r_t0 - r_prod[SGN_W-1:0];
                    r_r0    <= r_r1;
                    r_r1    <= r_r2;
                    r_state <= S_INVCHK;
                end
                S_INVFIN: begin
                    r_qinv    <= (r_r0 != PRIME_W'(1)) ? PRIME_W'(1) : w_tfix[PRIME_W-1:0];
                    r_pw_q    <= 1'b0;
                    r_mod     <= r_p;
                    r_exp     <= r_dp;
                    r_acc     <= PRIME_W'(1);
                    r_div_req <= '{1'b1, {32'd0, r_c}, r_p};
                    r_state   <= S_PWB;
                end
                S_PWB: if (w_div_rsp.done) begin
                    r_b     <= w_div_rsp.remainder;
                    r_state <= S_PWCHK;
                end
                S_PWCHK: begin
                    if (r_exp == '0) begin
                        if (!r_pw_q) begin
                            // first power done, switch to the q half
                            r_m1      <= r_acc;
                            r_pw_q    <= 1'b1;
                            r_mod     <= r_q;
                            r_exp     <= r_dq;
                            r_acc     <= PRIME_W'(1);
                            r_div_req <= '{1'b1, {32'd0, r_c}, r_q};
                            r_state   <= S_PWB;
                        end else begin
                            r_m2      <= r_acc;
                            r_div_req <= '{1'b1, {32'd0, r_acc}, r_p};
                            r_state   <= S_DIFF;
                        end
                    end else if (r_exp[0]) begin
                        r_state <= S_PWMA;
                    end else begin
                        r_state <= S_PWMB;
                    end
                end
                S_PWMA: r_state <= S_PWGA;
                S_PWGA: begin
                    r_div_req <= '{1'b1, r_prod[63:0], r_mod};
                    r_state   <= S_PWRA;
                end
                S_PWRA: if (w_div_rsp.done) begin
                    r_acc   <= w_div_rsp.remainder;
                    r_state <= S_PWMB;
                end
                S_PWMB: r_state <= S_PWGB;
                S_PWGB: begin
                    r_div_req <= '{1'b1, r_prod[63:0], r_mod};
                    r_state   <= S_PWRB;
                end
                S_PWRB: if (w_div_rsp.done) begin
                    r_b     <= w_div_rsp.remainder;
                    r_exp   <= r_exp >> 1;
                    r_state <= S_PWCHK;
                end
                S_DIFF: if (w_div_rsp.done) begin
                    r_sum   <= {1'b0, r_m1} + {1'b0, r_p} - {1'b0, w_div_rsp.remainder};
                    r_state <= S_DSUB;
                end
                S_DSUB: begin
                    r_diff  <= (r_sum >= {1'b0, r_p}) ? PRIME_W'(r_sum - {1'b0, r_p})
                                                      : r_sum[PRIME_W-1:0];
                    r_state <= S_HMUL;
                end
                S_HMUL: r_state <= S_HGO;
                S_HGO: begin
                    r_div_req <= '{1'b1, r_prod[63:0], r_p};
                    r_state   <= S_HRED;
                end
                S_HRED: if (w_div_rsp.done) begin
                    r_h     <= w_div_rsp.remainder;
                    r_state <= S_MMUL;
                end
                S_MMUL: r_state <= S_MADD;
                S_MADD: begin
                    r_out   <= {32'd0, r_m2} + r_prod[63:0];
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

    `RCD_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RCD_ASSERT(a_no_start_when_busy, r_div_req.start |-> !w_div_rsp.busy)
    `RCD_ASSERT(a_out_blocks_in, m_axis_tvalid |-> !s_axis_tready)

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// rsa crt decryption testbench
// streams ciphertexts through the block under several key settings written
// over apb, predicts each plaintext independently and checks every response
// ----------------------------------------------------------------------------
module testbench;
    import rcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int HOLD_CYCLES    = 3000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;   // [31:0] ciphertext
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [63:0]       m_axis_tdata;   // [63:0] plaintext
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rsa_crt_decrypt u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // key copy used for prediction
    logic [63:0] key_d;
    logic [31:0] key_p;
    logic [31:0] key_q;

    logic [31:0] cipher_queue[$];
    logic [63:0] plain_expected[$];
    int          mismatches;
    int          plains_seen;
    int          ciphers_sent;
    int          idle_mode;      // 0: sender light, receiver heavy; 1: swapped; 2: none
    bit          hold_req;
    bit          hold_done;
    int          hold_left;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] b;
        acc = 64'd1 % m;
        b   = base % m;
        while (e != 0) begin
            if (e[0]) acc = (acc * b) % m;
            e = e >> 1;
            b = (b * b) % m;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] m);
        longint r0, r1, r2, t0, t1, t2, qt;
        r0 = longint'(m);
        r1 = longint'(a % m);
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            r2 = r0 - qt * r1;
            t2 = t0 - qt * t1;
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        if (r0 != 1) return 64'd1;
        if (t0 < 0) t0 = t0 + longint'(m);
        return 64'(t0);
    endfunction

    function automatic logic [63:0] crt_plaintext(logic [31:0] c);
        logic [63:0] p, q, dp, dq, qinv, m1, m2, diff, h;
        p = {32'd0, key_p};
        q = {32'd0, key_q};
        if (p < 2 || q < 2) return 64'd0;
        dp   = key_d % (p - 1);
        dq   = key_d % (q - 1);
        qinv = mod_inverse(q, p);
        m1   = mod_pow({32'd0, c}, dp, p);
        m2   = mod_pow({32'd0, c}, dq, q);
        // difference kept in range by adding p
        diff = (m1 + p - (m2 % p)) % p;
        h    = (qinv * diff) % p;
        return m2 + h * q;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic bit sender_skips();
        if (idle_mode == 0) return $urandom_range(99) < 14;
        if (idle_mode == 1) return $urandom_range(99) < 70;
        return 1'b0;
    endfunction

    function automatic bit receiver_skips();
        if (idle_mode == 0) return $urandom_range(99) < 70;
        if (idle_mode == 1) return $urandom_range(99) < 14;
        return 1'b0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                plain_expected.push_back(crt_plaintext(s_axis_tdata));
                ciphers_sent++;
            end
            if (cipher_queue.size() > 0 && !sender_skips()) begin
                s_axis_tdata  <= cipher_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // response monitor and receiver stalls
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                plains_seen++;
                if (plain_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected plaintext %h", m_axis_tdata));
                end else begin
                    want = plain_expected.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("plaintext %h, expected %h",
                                                  m_axis_tdata, want));
                end
            end
            if (hold_req && !hold_done) begin
                // stay off until a result waits, then keep it waiting
                m_axis_tready <= 1'b0;
                if (m_axis_tvalid) begin
                    hold_left <= HOLD_CYCLES;
                    hold_done <= 1'b1;
                end
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !receiver_skips();
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding",
                     plain_expected.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_EXPONENT) key_d = val;
        else if (idx == REG_PRIME_P) key_p = val[31:0];
        else if (idx == REG_PRIME_Q) key_q = val[31:0];
    endtask

    task automatic set_key(input logic [63:0] d, input logic [31:0] p,
                           input logic [31:0] q);
        cfg_write(REG_EXPONENT, d);
        cfg_write(REG_PRIME_P, {32'd0, p});
        cfg_write(REG_PRIME_Q, {32'd0, q});
    endtask

    task automatic wait_drained();
        while (cipher_queue.size() > 0 || s_axis_tvalid || plain_expected.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_modulus();
        int bits;
        // mostly short moduli keep exponentiation short
        bits = ($urandom_range(9) == 0) ? 32 : $urandom_range(16, 2);
        if (bits == 32) return $urandom_range(32'hFFFFFFFF, 2);
        return $urandom_range((1 << bits) - 1, 2);
    endfunction

    initial begin
        logic [31:0] p, q;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        key_d         = 64'd1;
        key_p         = 32'd5;
        key_q         = 32'd3;
        mismatches    = 0;
        plains_seen   = 0;
        ciphers_sent  = 0;
        idle_mode     = 2;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key
        cipher_queue = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h55555555,
                         32'hAAAAAAAA};
        wait_drained();
        // widest moduli and all-ones exponent
        set_key(64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFB, 32'hFFFFFFFF);
        cipher_queue = '{32'hFFFFFFFF, 32'h12345678, 32'h2};
        wait_drained();
        // zero exponent
        set_key(64'd0, 32'd61, 32'd53);
        cipher_queue = '{32'h0, 32'hDEADBEEF};
        wait_drained();
        // equal moduli, no inverse
        set_key(64'd123, 32'd97, 32'd97);
        cipher_queue = '{32'h5, 32'hFFFFFFFE};
        wait_drained();
        // smallest moduli
        set_key(64'd7, 32'd2, 32'd2);
        cipher_queue = '{32'h3, 32'h0};
        wait_drained();
        // degenerate moduli give zero
        set_key(64'd9, 32'd1, 32'd13);
        cipher_queue = '{32'h77};
        wait_drained();
        set_key(64'd9, 32'd13, 32'd0);
        cipher_queue = '{32'h77};
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            idle_mode = (ph < 4) ? 0 : (ph < 7) ? 1 : 2;
            p = rand_modulus();
            q = rand_modulus();
            if ($urandom_range(4) == 0) q = p;
            set_key({$urandom, $urandom}, p, q);
            if (ph == 5) hold_req = 1'b1;
            for (int k = 0; k < 10; k++) cipher_queue.push_back($urandom);
            wait_drained();
        end
        repeat (200) @(posedge i_clk);

        $display("%0d ciphertexts decrypted across 17 key settings, %0d responses checked",
                 ciphers_sent, plains_seen);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
